[hw/rtl/lpms_pkg.sv]
package lpms_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ITEMS = 1024;
  localparam int DEF_SIZE_BITS = 16;

  // Part count configuration register.
  localparam int PART_COUNT_W = 11;
  localparam logic [PART_COUNT_W-1:0] PART_COUNT_RESET = 11'd1;

  // Result fields.
  localparam int SUM_OUT_W   = 26;
  localparam int OUT_TDATA_W = 32;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK             = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY_PARTS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW       = 2'd2;

  typedef enum logic [2:0] {
    STATE_LOAD,
    STATE_DECIDE,
    STATE_SEARCH,
    STATE_WAIT,
    STATE_DONE
  } lpms_state_t;

endpackage

[hw/rtl/lpms_ram.sv]
module lpms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/lpms_probe.sv]
// Greedy scan over the stored items for one candidate limit: reads one item
// per cycle and counts how many contiguous parts that limit needs.
module lpms_probe #(
  parameter int MAX_ITEMS = 1024,
  parameter int SIZE_BITS = 16,
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int SUM_W  = SIZE_BITS + CNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUM_W-1:0]     limit,
  input  logic [CNT_W-1:0]     item_count,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  input  logic [SIZE_BITS-1:0] rd_data,
  output logic                 done,
  output logic [CNT_W-1:0]     parts
);

  logic             issuing;
  logic             dval;
  logic             dlast;
  logic [CNT_W-1:0] idx;
  logic [SUM_W-1:0] limit_q;
  logic [SUM_W-1:0] acc;
  logic             last_issue;
  logic [SUM_W:0]   acc_plus;
  logic             fits;

  assign last_issue = (idx == (item_count - CNT_W'(1)));
  assign rd_en      = issuing;
  assign rd_addr    = idx[ADDR_W-1:0];

  assign acc_plus = {1'b0, acc} + (SUM_W + 1)'(rd_data);
  assign fits     = (acc_plus <= {1'b0, limit_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      dval    <= 1'b0;
      dlast   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done  <= dval && dlast;
      dval  <= issuing;
      dlast <= issuing && last_issue;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && last_issue) begin
        issuing <= 1'b0;
      end
    end
  end

  // The read data arrives in the cycle after its address, so the accumulator
  // handles each item in the cycle after the address counter issued it.
  always_ff @(posedge clk) begin
    if (start) begin
      idx     <= '0;
      limit_q <= limit;
      acc     <= '0;
      parts   <= CNT_W'(1);
    end else begin
      if (issuing) begin
        idx <= idx + CNT_W'(1);
      end
      if (dval) begin
        if (fits) begin
          acc <= acc_plus[SUM_W-1:0];
        end else begin
          parts <= parts + CNT_W'(1);
          acc   <= SUM_W'(rd_data);
        end
      end
    end
  end

endmodule

[hw/rtl/linear_partition_min_max_sum_core.sv]
// Splits a set of item sizes into part_count contiguous parts so that the
// largest part sum is as small as possible. While the block is loading, items
// stream in at one per cycle and are written to an item store; the transaction
// with tlast ends the set. The block then stops accepting items and runs a
// binary search on the limit between the largest item and the total, each
// probe being a greedy scan that reads the single-read-port store one item
// per cycle. A set needs at most ceil(log2(total - max + 1)) probes. An error
// result (overflow or too many parts) goes from the decide state straight to
// the done state and from there to the output register once that is free;
// the block is ready again in the same cycle that a result is loaded there.
// The result transaction carries the sum in tdata and the status in tuser;
// it sits in an output register, so loading of the next set may begin before
// it is taken.
// Items beyond MAX_ITEMS are dropped and reported with the overflow status.
// part_count may only be written while the block is idle; zero acts as one.
module linear_partition_min_max_sum_core
  import lpms_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int SIZE_BITS = DEF_SIZE_BITS,
  localparam int IN_TDATA_W = ((SIZE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration: part_count.
  input  logic                    cfg_wr_en,
  input  logic [PART_COUNT_W-1:0] cfg_wr_data,
  // Input items.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // [SIZE_BITS-1:0] item_size
  input  logic                    s_axis_tlast,  // last_item
  // Results.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // [25:0] min_max_sum
  output logic [STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_W  = SIZE_BITS + CNT_W;
  localparam int CMP_W  = (PART_COUNT_W > CNT_W) ? PART_COUNT_W : CNT_W;

  lpms_state_t state, state_next;

  logic [PART_COUNT_W-1:0] part_count;
  logic [CNT_W-1:0]        item_count;
  logic [SIZE_BITS-1:0]    running_max;
  logic [SUM_W-1:0]        running_total;
  logic                    overflow_seen;
  logic [SUM_W-1:0]        lo;
  logic [SUM_W-1:0]        hi;
  logic [SUM_W-1:0]        mid;
  logic [SUM_OUT_W-1:0]    out_sum;
  logic [STATUS_W-1:0]     out_status;
  logic [STATUS_W-1:0]     set_status;

  logic                    in_accept;
  logic                    store_full;
  logic                    store_wr;
  logic [SIZE_BITS-1:0]    item_size;
  logic [PART_COUNT_W-1:0] parts_eff;
  logic                    too_many_parts;
  logic                    search_open;
  logic [SUM_W:0]          lo_hi;
  logic [SUM_W-1:0]        mid_calc;
  logic                    feasible;
  logic                    probe_start;
  logic                    out_load;
  logic [SUM_W+SUM_OUT_W-1:0] lo_ext;

  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [SIZE_BITS-1:0]    rd_data;
  logic                    probe_done;
  logic [CNT_W-1:0]        probe_parts;

  assign item_size  = s_axis_tdata[SIZE_BITS-1:0];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign store_full = (item_count == CNT_W'(MAX_ITEMS));
  assign store_wr   = in_accept && !store_full;

  assign parts_eff      = (part_count == '0) ? PART_COUNT_W'(1) : part_count;
  assign too_many_parts = (CMP_W'(parts_eff) > CMP_W'(item_count));
  assign search_open    = (lo < hi);
  assign lo_hi          = {1'b0, lo} + {1'b0, hi};
  assign mid_calc       = lo_hi[SUM_W:1];
  assign feasible       = (CMP_W'(probe_parts) <= CMP_W'(parts_eff));
  assign lo_ext         = {{SUM_OUT_W{1'b0}}, lo};

  lpms_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (item_count[ADDR_W-1:0]),
    .wr_data (item_size),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpms_probe #(
    .MAX_ITEMS (MAX_ITEMS),
    .SIZE_BITS (SIZE_BITS)
  ) u_probe (
    .clk        (clk),
    .rst        (rst),
    .start      (probe_start),
    .limit      (mid_calc),
    .item_count (item_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done       (probe_done),
    .parts      (probe_parts)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      STATE_LOAD: begin
        if (in_accept && s_axis_tlast) begin
          state_next = STATE_DECIDE;
        end
      end
      STATE_DECIDE: begin
        if (overflow_seen || too_many_parts) begin
          state_next = STATE_DONE;
        end else begin
          state_next = STATE_SEARCH;
        end
      end
      STATE_SEARCH: begin
        if (search_open) begin
          state_next = STATE_WAIT;
        end else begin
          state_next = STATE_DONE;
        end
      end
      STATE_WAIT: begin
        if (probe_done) begin
          state_next = STATE_SEARCH;
        end
      end
      STATE_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = STATE_LOAD;
        end
      end
      default: state_next = STATE_LOAD;
    endcase
  end

  // Output decode.
  always_comb begin
    s_axis_tready = 1'b0;
    probe_start   = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      STATE_LOAD:   s_axis_tready = 1'b1;
      STATE_SEARCH: probe_start   = search_open;
      STATE_DONE:   out_load      = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= STATE_LOAD;
      part_count    <= PART_COUNT_RESET;
      item_count    <= '0;
      running_max   <= '0;
      running_total <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        part_count <= cfg_wr_data;
      end
      if (store_wr) begin
        item_count    <= item_count + CNT_W'(1);
        running_total <= running_total + SUM_W'(item_size);
        if (item_size > running_max) begin
          running_max <= item_size;
        end
      end else if (in_accept) begin
        overflow_seen <= 1'b1;
      end
      // The set is cleared once its result has gone to the output register.
      if (out_load) begin
        item_count    <= '0;
        running_max   <= '0;
        running_total <= '0;
        overflow_seen <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Search interval and result payload. On an error the sum is forced to
  // zero through lo, which always holds the value to be reported. The status
  // of a set is held apart from the output register, so a result that is
  // still waiting keeps its status while the next set is decided.
  always_ff @(posedge clk) begin
    unique case (state)
      STATE_DECIDE: begin
        if (overflow_seen) begin
          lo         <= '0;
          set_status <= STATUS_OVERFLOW;
        end else if (too_many_parts) begin
          lo         <= '0;
          set_status <= STATUS_TOO_MANY_PARTS;
        end else begin
          lo         <= SUM_W'(running_max);
          hi         <= running_total;
          set_status <= STATUS_OK;
        end
      end
      STATE_SEARCH: begin
        if (search_open) begin
          mid <= mid_calc;
        end
      end
      STATE_WAIT: begin
        if (probe_done) begin
          if (feasible) begin
            hi <= mid;
          end else begin
            lo <= mid + SUM_W'(1);
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_sum    <= lo_ext[SUM_OUT_W-1:0];
      out_status <= set_status;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - SUM_OUT_W){1'b0}}, out_sum};
  assign m_axis_tuser = out_status;

  a_error_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("result with error status carries a non-zero sum");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == STATE_WAIT) |-> ((mid >= lo) && (mid < hi)))
    else $error("probe limit outside the search interval");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (item_count <= CNT_W'(MAX_ITEMS)))
    else $error("item count beyond store depth");

  a_max_le_total: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(running_max) <= running_total))
    else $error("running maximum exceeds running total");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    probe_done |-> (state == STATE_WAIT))
    else $error("probe finished outside the wait state");

endmodule

[tb/partition_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the partition core. It keeps its own copy of the
// collected set and of part_count, works out the expected result for every
// set that ends (the smallest largest-part sum, or an error status with a
// zero sum), and compares each result with the oldest pending prediction.
module partition_checker
  import lpms_pkg::*;
#(
  parameter int IN_W = ((DEF_SIZE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [PART_COUNT_W-1:0] cfg_wr_data,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [IN_W-1:0]         s_axis_tdata,
  input  logic                    s_axis_tlast,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic [STATUS_W-1:0]     m_axis_tuser,
  output int                      fail_count,
  output int                      pending,
  output int                      ok_count,
  output int                      short_count,
  output int                      overflow_count
);

  typedef struct packed {
    logic [SUM_OUT_W-1:0] sum;
    logic [STATUS_W-1:0]  status;
  } partition_t;

  partition_t partition_q[$];

  logic [DEF_SIZE_BITS-1:0] sizes [DEF_MAX_ITEMS];
  int unsigned              set_len;
  longint unsigned          set_max;
  longint unsigned          set_total;
  bit                       dropped;
  logic [PART_COUNT_W-1:0]  parts_cfg;

  int fails = 0;
  int n_ok = 0;
  int n_short = 0;
  int n_overflow = 0;

  function automatic void clear_set();
    set_len   = 0;
    set_max   = 0;
    set_total = 0;
    dropped   = 1'b0;
  endfunction

  // Greedy left-to-right scan: parts needed when no part may exceed limit.
  function automatic longint unsigned parts_for_limit(longint unsigned limit);
    longint unsigned parts;
    longint unsigned acc;
    int unsigned     i;
    parts = 1;
    acc   = 0;
    for (i = 0; i < set_len; i++) begin
      if (acc + sizes[i] <= limit) begin
        acc += sizes[i];
      end else begin
        parts++;
        acc = sizes[i];
      end
    end
    return parts;
  endfunction

  function automatic longint unsigned smallest_limit(longint unsigned parts);
    longint lo;
    longint hi;
    longint mid;
    lo = set_max;
    hi = set_total;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (parts_for_limit(mid) > parts) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  always @(posedge clk) begin : watch
    partition_t      want;
    longint unsigned parts;
    if (rst) begin
      partition_q.delete();
      clear_set();
      parts_cfg = PART_COUNT_RESET;
    end else begin
      // Results are taken before items, so a result can never be matched
      // against a prediction made at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (partition_q.size() == 0) begin
          fails++;
          $display("%0t: result transaction with nothing expected, actual sum %0d status %0d",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = partition_q.pop_front();
          if (m_axis_tdata !== OUT_TDATA_W'(want.sum)) begin
            fails++;
            $display("%0t: min_max_sum expected %0d, actual %0d", $time, want.sum,
                     m_axis_tdata);
          end
          if (m_axis_tuser !== want.status) begin
            fails++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status,
                     m_axis_tuser);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (set_len < DEF_MAX_ITEMS) begin
          sizes[set_len] = s_axis_tdata[DEF_SIZE_BITS-1:0];
          set_len++;
          if (s_axis_tdata[DEF_SIZE_BITS-1:0] > set_max) begin
            set_max = s_axis_tdata[DEF_SIZE_BITS-1:0];
          end
          set_total += s_axis_tdata[DEF_SIZE_BITS-1:0];
        end else begin
          dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          parts = (parts_cfg == '0) ? 1 : parts_cfg;
          want.sum = '0;
          if (dropped) begin
            want.status = STATUS_OVERFLOW;
            n_overflow++;
          end else if (parts > set_len) begin
            want.status = STATUS_TOO_MANY_PARTS;
            n_short++;
          end else begin
            want.status = STATUS_OK;
            want.sum    = SUM_OUT_W'(smallest_limit(parts));
            n_ok++;
          end
          partition_q.push_back(want);
          clear_set();
        end
      end

      if (cfg_wr_en) begin
        parts_cfg = cfg_wr_data;
      end
    end
    pending        <= partition_q.size();
    fail_count     <= fails;
    ok_count       <= n_ok;
    short_count    <= n_short;
    overflow_count <= n_overflow;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench
  import lpms_pkg::*;
();

  localparam int SIZE_W        = DEF_SIZE_BITS;
  localparam int IN_W          = ((DEF_SIZE_BITS + 7) / 8) * 8;
  localparam int SET_CAP       = DEF_MAX_ITEMS;
  localparam int RANDOM_ITEMS  = 170;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [PART_COUNT_W-1:0] cfg_wr_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_W-1:0]         s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]     m_axis_tuser;

  int fail_count;
  int pending;
  int ok_count;
  int short_count;
  int overflow_count;

  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;
  int items_sent;
  int sets_sent;

  linear_partition_min_max_sum_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  partition_checker #(.IN_W(IN_W)) u_partition_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .ok_count       (ok_count),
    .short_count    (short_count),
    .overflow_count (overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int burst;
    int n;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (burst > 0) begin
        m_axis_tready <= 1'b0;
        burst--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        burst = $urandom_range(1, 15) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return SIZE_W'($urandom);
    end else if (r < 8) begin
      return SIZE_W'($urandom_range(0, 15));
    end else if (r == 8) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 16'hAAAA;
        default: return 16'h5555;
      endcase
    end
    return SIZE_W'($urandom_range(60000, 65535));
  endfunction

  task automatic send_item(input logic [SIZE_W-1:0] size, input bit last);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= size;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (last) sets_sent++;
  endtask

  task automatic send_set(input int len);
    int i;
    for (i = 0; i < len; i++) send_item(pick_size(), i == len - 1);
  endtask

  // Stops offering items and waits until every predicted result has been
  // taken, then lets the block settle before anything else happens.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_parts(input logic [PART_COUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int random_sent;
    int n_sets;
    int eff;
    int len;
    int r;
    int i;
    logic [PART_COUNT_W-1:0] pc;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    rx_hold_req   = 1'b0;
    items_sent    = 0;
    sets_sent     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Part count still at its reset value of one.
    send_item('0, 1'b1);
    send_item('1, 1'b1);
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    wait_drained();

    write_parts(PART_COUNT_W'(2));
    for (i = 1; i <= 5; i++) send_item(SIZE_W'(i), i == 5);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b1);
    send_item(SIZE_W'(7), 1'b1);
    wait_drained();

    // A part count of zero behaves as one.
    write_parts(PART_COUNT_W'(0));
    send_item(SIZE_W'(3), 1'b0);
    send_item(SIZE_W'(9), 1'b1);
    wait_drained();

    write_parts(PART_COUNT_W'(3));
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(SIZE_W'(1), 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h5555, 1'b1);
    wait_drained();

    write_parts(PART_COUNT_W'(1024));
    for (i = 0; i < 4; i++) send_item(pick_size(), i == 3);
    wait_drained();
    write_parts('1);
    send_item(16'h1234, 1'b1);
    wait_drained();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Two items past capacity, the last transaction itself being dropped,
    // then a short set to show that the overflow flag was cleared.
    write_parts(PART_COUNT_W'(5));
    for (i = 0; i < SET_CAP + 2; i++) send_item(pick_size(), i == SET_CAP + 1);
    send_set(6);
    wait_drained();

    // Long hold-off on the result side while sets keep arriving.
    write_parts(PART_COUNT_W'(2));
    rx_hold_req = 1'b1;
    for (i = 0; i < 6; i++) send_set(4);
    wait_drained();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent > RANDOM_ITEMS * 9 / 10) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        pc = '0;
      end else if (r == 1) begin
        pc = PART_COUNT_W'($urandom_range(SET_CAP + 1, 2047));
      end else if (r == 2) begin
        pc = PART_COUNT_W'($urandom_range(9, 30));
      end else begin
        pc = PART_COUNT_W'($urandom_range(1, 6));
      end
      write_parts(pc);
      eff = (pc == '0) ? 1 : int'(pc);
      n_sets = $urandom_range(2, 6);
      for (i = 0; i < n_sets; i++) begin
        if (eff > SET_CAP || $urandom_range(0, 7) == 0) begin
          len = $urandom_range(1, (eff > 24) ? 24 : eff);
        end else begin
          len = eff + $urandom_range(0, 24);
        end
        send_set(len);
        random_sent += len;
      end
      wait_drained();
    end

    $display("Sent %0d items in %0d sets; part counts from 0 to 2047 and a full store.",
             items_sent, sets_sent);
    $display("Results checked: %0d ok, %0d too many parts, %0d overflow.",
             ok_count, short_count, overflow_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
